@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define FRU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define FRU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// State right after a reset cycle
`define FRU_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

@@ hdl/fru_pkg.sv @@
// Shared constants, widths and types of the Fresnel reflectance pipeline.
// No dependencies; the other files use it, but for fru_div, fru_sqrt and assert_macros.svh.
package fru_pkg;

  // number formats
  localparam int FRAC_BITS = 14;
  localparam int Q30       = 30;
  localparam int FIELD_W   = 16;
  localparam int NUM_IN    = 8;
  localparam int IN_W      = FIELD_W * NUM_IN;
  localparam int OUT_W     = 16;

  // field slots in the input beat, lowest first
  localparam int F_INC_X  = 0;
  localparam int F_INC_Y  = 1;
  localparam int F_INC_Z  = 2;
  localparam int F_NRM_X  = 3;
  localparam int F_NRM_Y  = 4;
  localparam int F_NRM_Z  = 5;
  localparam int F_IDX_FR = 6;
  localparam int F_IDX_TO = 7;

  // datapath widths
  localparam int PRD_W   = 2 * FIELD_W;          // one dot product term
  localparam int DOT_W   = PRD_W + 2;            // sum of three terms
  localparam int MAG_W   = Q30 + 1;              // |cosi| in Q30, up to 1.0
  localparam int MAGSQ_W = 2 * MAG_W;
  localparam int NSQ_W   = 2 * FIELD_W;          // index squared
  localparam int LHS_W   = NSQ_W + MAG_W;        // n1^2 * s
  localparam int QUO_W   = Q30 + 1;              // sin2t quotient
  localparam int DHI_W   = LHS_W - QUO_W;        // upper dividend bits
  localparam int ROOT_W  = Q30 + 1;              // cost
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int TERM_W  = FIELD_W + MAG_W;      // n * cos products
  localparam int SGN_W   = TERM_W + 2;           // signed sums of two terms
  localparam int RAT_W   = TERM_W + 1;           // magnitude of those sums
  localparam int RQ_W    = 31;                   // ratio in Q31
  localparam int RSQ_W   = 2 * RQ_W;             // squared ratio in Q62
  localparam int SUM_W   = RSQ_W + 2;
  localparam int RES_SH  = RSQ_W + 1 - (OUT_W - 1);

  // cosine scale shift from the product format to Q30
  localparam int MAG_SHIFT = 2 * FRAC_BITS - Q30;
  localparam int MAG_SHL   = (MAG_SHIFT < 0) ? -MAG_SHIFT : 0;
  localparam int MAG_SHR   = (MAG_SHIFT > 0) ? MAG_SHIFT : 0;

  // constants
  localparam logic [MAG_W-1:0]   ONE_Q30   = MAG_W'(1) << Q30;
  localparam logic [OUT_W-1:0]   ONE_Q15   = OUT_W'(1) << (OUT_W - 1);
  localparam logic [RSQ_W:0]     ONE_Q62   = (RSQ_W + 1)'(1) << RSQ_W;
  localparam logic [SUM_W-1:0]   RES_HALF  = SUM_W'(1) << (RES_SH - 1);

  // per-item data that rides beside the divide and root units
  typedef struct packed {
    logic               tir;
    logic               cneg;
    logic [MAG_W-1:0]   mag;
    logic [FIELD_W-1:0] n1;
    logic [FIELD_W-1:0] n2;
  } fru_geo_t;

  // result flags that ride beside the s ratio divider
  typedef struct packed {
    logic tir;
    logic zero;
    logic ge;
  } fru_rflag_t;

endpackage

@@ hdl/fru_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package; side data travels with each item unchanged.
module fru_div #(
  parameter int VW = 32,
  parameter int QB = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_hi,     // upper dividend part, below the divisor
  input  logic [QB-1:0] in_lo,     // lower dividend bits, shifted in one a stage
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QB-1:0] vld_q;
  logic [VW-1:0] rem_q  [QB];
  logic [QB-1:0] lo_q   [QB];
  logic [QB-1:0] quo_q  [QB];
  logic [VW-1:0] den_q  [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          v_i;
    logic [VW-1:0] rem_i;
    logic [VW-1:0] den_i;
    logic [QB-1:0] lo_i;
    logic [QB-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_hi;
      assign den_i  = in_den;
      assign lo_i   = in_lo;
      assign quo_i  = '0;
      assign side_i = in_side;
    end else begin : g_rest
      assign v_i    = vld_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign den_i  = den_q[k-1];
      assign lo_i   = lo_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign side_i = side_q[k-1];
    end

    // one trial subtract
    assign trial = {rem_i, lo_i[QB-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
        lo_q[k]   <= lo_i << 1;
        quo_q[k]  <= {quo_i[QB-2:0], ge};
        den_q[k]  <= den_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[QB-1];
  assign out_quo   = quo_q[QB-1];
  assign out_side  = side_q[QB-1];

endmodule

@@ hdl/fru_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Uses no package; side data travels with each item unchanged.
module fru_sqrt #(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic [RW-1:0]   vld_q;
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SW-1:0]   side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_i;
    logic [RW:0]     rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] rad_i;
    logic [SW-1:0]   side_i;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
    end else begin : g_rest
      assign v_i    = vld_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
      assign side_i = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[RW:0] : cur[RW:0];
        root_q[k] <= {root_i[RW-2:0], ge};
        rad_q[k]  <= rad_i << 2;
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_side  = side_q[RW-1];

endmodule

@@ hdl/fru_front.sv @@
// Front stages: dot product, |cosi| in Q30, 1 - cosi^2, n1^2 * s and the
// total internal reflection test. Depends on fru_pkg.
module fru_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [fru_pkg::IN_W-1:0]     in_data,
  output logic                         out_valid,
  output logic [fru_pkg::LHS_W-1:0]    out_lhs,
  output logic [fru_pkg::NSQ_W-1:0]    out_n2sq,
  output fru_pkg::fru_geo_t            out_geo
);

  localparam int FW = fru_pkg::FIELD_W;

  logic signed [FW-1:0] ix, iy, iz, nx, ny, nz;
  logic [FW-1:0]        n1_in, n2_in;

  assign ix    = in_data[fru_pkg::F_INC_X*FW +: FW];
  assign iy    = in_data[fru_pkg::F_INC_Y*FW +: FW];
  assign iz    = in_data[fru_pkg::F_INC_Z*FW +: FW];
  assign nx    = in_data[fru_pkg::F_NRM_X*FW +: FW];
  assign ny    = in_data[fru_pkg::F_NRM_Y*FW +: FW];
  assign nz    = in_data[fru_pkg::F_NRM_Z*FW +: FW];
  assign n1_in = in_data[fru_pkg::F_IDX_FR*FW +: FW];
  assign n2_in = in_data[fru_pkg::F_IDX_TO*FW +: FW];

  logic [4:0] vld;

  // stage 1: products
  logic signed [fru_pkg::PRD_W-1:0] px1, py1, pz1;
  logic [fru_pkg::NSQ_W-1:0]        n1sq1, n2sq1;
  logic [FW-1:0]                    n1_1, n2_1;

  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= ix * nx;
      py1   <= iy * ny;
      pz1   <= iz * nz;
      n1sq1 <= n1_in * n1_in;
      n2sq1 <= n2_in * n2_in;
      n1_1  <= n1_in;
      n2_1  <= n2_in;
    end
  end

  // stage 2: dot sum, sign, magnitude in Q30 with saturation
  logic signed [fru_pkg::DOT_W-1:0] dot;
  logic [fru_pkg::DOT_W-1:0]        dot_abs;
  logic [63:0]                      mag_wide;
  logic [fru_pkg::MAG_W-1:0]        mag_sat;

  assign dot      = fru_pkg::DOT_W'(px1) + fru_pkg::DOT_W'(py1) + fru_pkg::DOT_W'(pz1);
  assign dot_abs  = dot[fru_pkg::DOT_W-1] ? fru_pkg::DOT_W'(-dot) : fru_pkg::DOT_W'(dot);
  assign mag_wide = (64'(dot_abs) << fru_pkg::MAG_SHL) >> fru_pkg::MAG_SHR;
  assign mag_sat  = (mag_wide > 64'(fru_pkg::ONE_Q30)) ? fru_pkg::ONE_Q30
                                                        : mag_wide[fru_pkg::MAG_W-1:0];

  logic [fru_pkg::MAG_W-1:0] mag2;
  logic                      cneg2;
  logic [fru_pkg::NSQ_W-1:0] n1sq2, n2sq2;
  logic [FW-1:0]             n1_2, n2_2;

  always_ff @(posedge clk) begin
    if (en) begin
      mag2  <= mag_sat;
      cneg2 <= !dot[fru_pkg::DOT_W-1] && (dot != '0);
      n1sq2 <= n1sq1;
      n2sq2 <= n2sq1;
      n1_2  <= n1_1;
      n2_2  <= n2_1;
    end
  end

  // stage 3: cosi^2
  logic [fru_pkg::MAGSQ_W-1:0] magsq3;
  logic [fru_pkg::MAG_W-1:0]   mag3;
  logic                        cneg3;
  logic [fru_pkg::NSQ_W-1:0]   n1sq3, n2sq3;
  logic [FW-1:0]               n1_3, n2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      magsq3 <= mag2 * mag2;
      mag3   <= mag2;
      cneg3  <= cneg2;
      n1sq3  <= n1sq2;
      n2sq3  <= n2sq2;
      n1_3   <= n1_2;
      n2_3   <= n2_2;
    end
  end

  // stage 4: s = floor((2^60 - cosi^2) / 2^30)
  logic [fru_pkg::MAG_W:0] s_full;

  assign s_full = (fru_pkg::MAG_W + 1)'(fru_pkg::ONE_Q30)
                - magsq3[fru_pkg::MAGSQ_W-1:fru_pkg::Q30]
                - (fru_pkg::MAG_W + 1)'(|magsq3[fru_pkg::Q30-1:0]);

  logic [fru_pkg::MAG_W-1:0] s4, mag4;
  logic                      cneg4;
  logic [fru_pkg::NSQ_W-1:0] n1sq4, n2sq4;
  logic [FW-1:0]             n1_4, n2_4;

  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= s_full[fru_pkg::MAG_W-1:0];
      mag4  <= mag3;
      cneg4 <= cneg3;
      n1sq4 <= n1sq3;
      n2sq4 <= n2sq3;
      n1_4  <= n1_3;
      n2_4  <= n2_3;
    end
  end

  // stage 5: n1^2 * s
  logic [fru_pkg::LHS_W-1:0] lhs5;
  logic [fru_pkg::MAG_W-1:0] mag5;
  logic                      cneg5;
  logic [fru_pkg::NSQ_W-1:0] n2sq5;
  logic [FW-1:0]             n1_5, n2_5;

  always_ff @(posedge clk) begin
    if (en) begin
      lhs5  <= n1sq4 * s4;
      mag5  <= mag4;
      cneg5 <= cneg4;
      n2sq5 <= n2sq4;
      n1_5  <= n1_4;
      n2_5  <= n2_4;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // exact TIR test: n1^2 * s > n2^2 * 2^30, or no outgoing index
  assign out_valid    = vld[4];
  assign out_lhs      = lhs5;
  assign out_n2sq     = n2sq5;
  assign out_geo.tir  = (n2_5 == '0) || (lhs5 > {n2sq5, fru_pkg::Q30'(0)});
  assign out_geo.cneg = cneg5;
  assign out_geo.mag  = mag5;
  assign out_geo.n1   = n1_5;
  assign out_geo.n2   = n2_5;

endmodule

@@ hdl/fru_back.sv @@
// Back stages: the s and p Fresnel ratios, their division, squares, mean
// and rounding to Q1.15. Depends on fru_pkg and fru_div.
module fru_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [fru_pkg::ROOT_W-1:0]  in_cost,
  input  fru_pkg::fru_geo_t           in_geo,
  output logic                        out_valid,
  output logic [fru_pkg::OUT_W-1:0]   out_refl,
  output logic                        out_tir
);

  localparam int TW = fru_pkg::TERM_W;
  localparam int SW = fru_pkg::SGN_W;
  localparam int RW = fru_pkg::RAT_W;

  logic [2:0] vld;

  // stage 1: the four index-cosine products
  logic [TW-1:0] a1, b1, c1, d1;
  logic          cneg1, tir1;

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= in_geo.n1 * in_geo.mag;
      b1    <= in_geo.n2 * in_cost;
      c1    <= in_geo.n1 * in_cost;
      d1    <= in_geo.n2 * in_geo.mag;
      cneg1 <= in_geo.cneg;
      tir1  <= in_geo.tir;
    end
  end

  // stage 2: signed numerators and denominators
  logic signed [SW-1:0] sa, sd, ea, eb, ec, ed;

  assign ea = $signed({2'b00, a1});
  assign eb = $signed({2'b00, b1});
  assign ec = $signed({2'b00, c1});
  assign ed = $signed({2'b00, d1});
  assign sa = cneg1 ? -ea : ea;
  assign sd = cneg1 ? -ed : ed;

  logic signed [SW-1:0] ns2, ds2, np2, dp2;
  logic                 tir2;

  always_ff @(posedge clk) begin
    if (en) begin
      ns2  <= sa - eb;
      ds2  <= sa + eb;
      np2  <= ec - sd;
      dp2  <= ec + sd;
      tir2 <= tir1;
    end
  end

  // stage 3: magnitudes and zero denominator check
  logic [SW-1:0] ns_abs, ds_abs, np_abs, dp_abs;

  assign ns_abs = ns2[SW-1] ? SW'(-ns2) : SW'(ns2);
  assign ds_abs = ds2[SW-1] ? SW'(-ds2) : SW'(ds2);
  assign np_abs = np2[SW-1] ? SW'(-np2) : SW'(np2);
  assign dp_abs = dp2[SW-1] ? SW'(-dp2) : SW'(dp2);

  logic [RW-1:0] ns3, ds3, np3, dp3;
  logic          tir3, zero3;

  always_ff @(posedge clk) begin
    if (en) begin
      ns3   <= ns_abs[RW-1:0];
      ds3   <= ds_abs[RW-1:0];
      np3   <= np_abs[RW-1:0];
      dp3   <= dp_abs[RW-1:0];
      tir3  <= tir2;
      zero3 <= (ds2 == '0) || (dp2 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // ratio dividers, Q31 fraction of num/den
  fru_pkg::fru_rflag_t flag_in, flag_out;
  logic                ge_p_out;
  logic                div_valid;
  logic [fru_pkg::RQ_W-1:0] qs, qp;

  assign flag_in.tir  = tir3;
  assign flag_in.zero = zero3;
  assign flag_in.ge   = ns3 >= ds3;

  fru_div #(
    .VW (RW),
    .QB (fru_pkg::RQ_W),
    .SW ($bits(fru_pkg::fru_rflag_t))
  ) u_div_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[2]),
    .in_hi     (ns3),
    .in_lo     ('0),
    .in_den    (ds3),
    .in_side   (flag_in),
    .out_valid (div_valid),
    .out_quo   (qs),
    .out_side  (flag_out)
  );

  fru_div #(
    .VW (RW),
    .QB (fru_pkg::RQ_W),
    .SW (1)
  ) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[2]),
    .in_hi     (np3),
    .in_lo     ('0),
    .in_den    (dp3),
    .in_side   (np3 >= dp3),
    .out_valid (),
    .out_quo   (qp),
    .out_side  (ge_p_out)
  );

  // stage 4: squares, a ratio at or above one counts as exactly one
  logic [fru_pkg::RSQ_W-1:0] qs_sq, qp_sq;

  assign qs_sq = fru_pkg::RSQ_W'(qs) * fru_pkg::RSQ_W'(qs);
  assign qp_sq = fru_pkg::RSQ_W'(qp) * fru_pkg::RSQ_W'(qp);

  logic [fru_pkg::RSQ_W:0] sq_s4, sq_p4;
  logic                    v4, tir4, zero4;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s4 <= flag_out.ge ? fru_pkg::ONE_Q62 : {1'b0, qs_sq};
      sq_p4 <= ge_p_out    ? fru_pkg::ONE_Q62 : {1'b0, qp_sq};
      tir4  <= flag_out.tir;
      zero4 <= flag_out.zero;
    end
  end

  // stage 5: mean, round half up, saturate, special cases
  logic [fru_pkg::SUM_W-1:0] sum5, rnd5;
  logic [fru_pkg::OUT_W-1:0] r5;

  assign sum5 = fru_pkg::SUM_W'(sq_s4) + fru_pkg::SUM_W'(sq_p4);
  assign rnd5 = sum5 + fru_pkg::RES_HALF;
  assign r5   = rnd5[fru_pkg::RES_SH +: fru_pkg::OUT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (tir4 || zero4 || (r5 > fru_pkg::ONE_Q15)) begin
        out_refl <= fru_pkg::ONE_Q15;
      end else begin
        out_refl <= r5;
      end
      out_tir <= tir4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= div_valid;
      out_valid <= v4;
    end
  end

endmodule

@@ hdl/fresnel_reflectance_unit_core.sv @@
// Top level of the unpolarized Fresnel reflectance pipeline.
// Depends on fru_pkg, fru_front, fru_div, fru_sqrt and fru_back.
//
// Usage:
//   Slave channel s_*: one beat per ray hit, eight 16-bit fields in s_tdata.
//   Master channel m_*: one beat per hit, reflectance in m_tdata (Q1.15,
//   0x8000 = 1.0) and the total internal reflection flag in m_tuser.
//   Results leave in the order the hits came in.
//   Throughput: one hit per cycle while the output is not stalled.
//   Depth: 104 register stages, the first loaded at the accepting edge.
//   Set by the bit-per-stage
//   pipelines: 31 stages for the sin2t divide, 31 for the cos(t) square
//   root, 31 for the ratio divides, plus 10 arithmetic stages and the
//   output register.
//   Stall: while m_tready is low the result is held and one more result is
//   caught in a skid register; after that s_tready drops and the whole
//   pipeline holds until the output is taken. s_tready comes from a
//   register.
//   Reset (rst, synchronous): all valid bits clear; the block holds no
//   other state and accepts beats as soon as reset is released.
module fresnel_reflectance_unit_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
  // index_from, index_to (16 bits each, lowest first)
  input  logic [fru_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // reflectance
  output logic [fru_pkg::OUT_W-1:0]  m_tdata,
  // total_internal
  output logic                       m_tuser
);

  logic en;
  logic skid_valid;

  // pipeline moves whenever the skid slot is empty
  assign en       = !skid_valid;
  assign s_tready = !skid_valid;

  // front stages
  logic                       fr_valid;
  logic [fru_pkg::LHS_W-1:0]  fr_lhs;
  logic [fru_pkg::NSQ_W-1:0]  fr_n2sq;
  fru_pkg::fru_geo_t          fr_geo;

  fru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid && s_tready),
    .in_data   (s_tdata),
    .out_valid (fr_valid),
    .out_lhs   (fr_lhs),
    .out_n2sq  (fr_n2sq),
    .out_geo   (fr_geo)
  );

  // sin2t = floor(n1^2 * s / n2^2)
  logic                       dv_valid;
  logic [fru_pkg::QUO_W-1:0]  dv_t;
  fru_pkg::fru_geo_t          dv_geo;

  fru_div #(
    .VW (fru_pkg::NSQ_W),
    .QB (fru_pkg::QUO_W),
    .SW ($bits(fru_pkg::fru_geo_t))
  ) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_hi     (fr_lhs[fru_pkg::LHS_W-1:fru_pkg::QUO_W]),
    .in_lo     (fr_lhs[fru_pkg::QUO_W-1:0]),
    .in_den    (fr_n2sq),
    .in_side   (fr_geo),
    .out_valid (dv_valid),
    .out_quo   (dv_t),
    .out_side  (dv_geo)
  );

  // cost = floor(sqrt((1 - sin2t) * 2^30))
  logic [fru_pkg::MAG_W-1:0]  one_minus_t;
  logic [fru_pkg::RAD_W-1:0]  rad;
  logic                       sq_valid;
  logic [fru_pkg::ROOT_W-1:0] sq_cost;
  fru_pkg::fru_geo_t          sq_geo;

  assign one_minus_t = fru_pkg::ONE_Q30 - dv_t;
  assign rad         = fru_pkg::RAD_W'({one_minus_t, fru_pkg::Q30'(0)});

  fru_sqrt #(
    .RW (fru_pkg::ROOT_W),
    .SW ($bits(fru_pkg::fru_geo_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .in_rad    (rad),
    .in_side   (dv_geo),
    .out_valid (sq_valid),
    .out_root  (sq_cost),
    .out_side  (sq_geo)
  );

  // ratios and final result
  logic                      bk_valid;
  logic [fru_pkg::OUT_W-1:0] bk_refl;
  logic                      bk_tir;

  fru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_cost   (sq_cost),
    .in_geo    (sq_geo),
    .out_valid (bk_valid),
    .out_refl  (bk_refl),
    .out_tir   (bk_tir)
  );

  // output register and skid slot
  logic [fru_pkg::OUT_W-1:0] skid_refl;
  logic                      skid_tir;
  logic                      out_free;
  logic                      push;

  assign out_free = !m_tvalid || m_tready;
  assign push     = en && bk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_refl;
        m_tuser <= skid_tir;
      end else if (push) begin
        m_tdata <= bk_refl;
        m_tuser <= bk_tir;
      end
    end else if (push) begin
      skid_refl <= bk_refl;
      skid_tir  <= bk_tir;
    end
  end

endmodule

@@ hdl/fru_checker.sv @@
// Port-level checks of the reflectance pipeline, bound to the top level.
// Depends on assert_macros.svh and fru_pkg.
`include "assert_macros.svh"

module fru_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [fru_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);

  // stalled result beat holds
  `FRU_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

  // total internal reflection always reports full reflectance
  `FRU_ASSERT_IMP(a_tir_full, clk, rst, m_tvalid && m_tuser, m_tdata == fru_pkg::ONE_Q15, "TIR beat without reflectance 1.0")

  // input side only stops after an output stall
  `FRU_ASSERT_IMP(a_stall_cause, clk, rst, $fell(s_tready), $past(m_tvalid && !m_tready), "s_tready dropped without output stall")

  // reset empties the output and opens the input
  `FRU_ASSERT_RST(a_reset, clk, rst, !m_tvalid && s_tready, "bad state after reset")

endmodule

bind fresnel_reflectance_unit_core fru_checker u_fru_checker (.*);

@@ sim/fru_scoreboard.sv @@
// Result checker for the Fresnel reflectance core: watches both stream channels,
// predicts each result from the accepted hit and compares in order. Uses fru_pkg.
`timescale 1ns / 100ps

module fru_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [fru_pkg::IN_W-1:0]         s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [fru_pkg::OUT_W-1:0]        m_tdata,
  input  logic                             m_tuser,
  output int                               fail_count,
  output int                               pending,
  output int                               tir_seen,
  output int                               checked
);
  import fru_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] refl;
    logic             tir;
  } refl_t;

  refl_t pending_refl[$];

  // integer square root, floor
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // (num/den)^2 in Q62, clipped at one
  function automatic logic [63:0] ratio_square(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem;
    if (num >= den) return 64'd1 << 62;
    q = 0;
    rem = num;
    for (int i = 0; i < 31; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q * q;
  endfunction

  function automatic logic [63:0] absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic refl_t predict_reflectance(logic [IN_W-1:0] hit);
    refl_t res;
    longint d, c, ns, ds, np, dp;
    logic [63:0] mag, s, n1, n2, lhs, n2sq, t, cost, sum, r;
    logic cneg;
    d = longint'($signed(hit[16*F_INC_X +: 16])) * $signed(hit[16*F_NRM_X +: 16])
      + longint'($signed(hit[16*F_INC_Y +: 16])) * $signed(hit[16*F_NRM_Y +: 16])
      + longint'($signed(hit[16*F_INC_Z +: 16])) * $signed(hit[16*F_NRM_Z +: 16]);
    cneg = d > 0;
    mag = absv(d);
    if (MAG_SHIFT >= 0) mag = mag >> MAG_SHIFT;
    else mag = mag << (-MAG_SHIFT);
    if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
    s = ((64'd1 << 60) - mag * mag) >> 30;
    n1 = hit[16*F_IDX_FR +: 16];
    n2 = hit[16*F_IDX_TO +: 16];
    n2sq = n2 * n2;
    lhs = n1 * n1 * s;
    res.refl = ONE_Q15;
    res.tir = 1'b1;
    if (n2 == 0 || lhs > (n2sq << 30)) return res;
    res.tir = 1'b0;
    t = lhs / n2sq;
    cost = root_floor(((64'd1 << 30) - t) << 30);
    c = cneg ? -longint'(mag) : longint'(mag);
    ns = longint'(n1) * c - longint'(n2) * longint'(cost);
    ds = longint'(n1) * c + longint'(n2) * longint'(cost);
    np = longint'(n1) * longint'(cost) - longint'(n2) * c;
    dp = longint'(n1) * longint'(cost) + longint'(n2) * c;
    if (ds == 0 || dp == 0) return res;
    sum = ratio_square(absv(ns), absv(ds)) + ratio_square(absv(np), absv(dp));
    r = (sum + (64'd1 << 47)) >> 48;
    if (r > ONE_Q15) r = ONE_Q15;
    res.refl = r[OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    tir_seen = 0;
    checked = 0;
  end

  // capture hits and compare results at each accepting edge
  always @(posedge clk) begin
    refl_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) pending_refl.push_back(predict_reflectance(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_refl.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          want = pending_refl.pop_front();
          checked++;
          if (m_tuser) tir_seen++;
          if (m_tdata !== want.refl) report_mismatch("reflectance", m_tdata, want.refl);
          if (m_tuser !== want.tir) report_mismatch("total_internal", m_tuser, want.tir);
        end
      end
    end
    pending = pending_refl.size();
  end
endmodule

@@ sim/tb_fresnel_reflectance_unit_core.sv @@
// Testbench top for fresnel_reflectance_unit_core: drives ray hits in bursts,
// stalls the result side, and gives the verdict. Needs fru_pkg and fru_scoreboard.
`timescale 1ns / 100ps

module tb_fresnel_reflectance_unit_core;
  import fru_pkg::*;

  localparam int LATENCY = 104;
  localparam int RANDOM_HITS = 700;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  int               fail_count, pending, tir_seen, checked;
  int               hits_sent = 0;
  logic             stall_on = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fresnel_reflectance_unit_core dut (.*);

  fru_scoreboard checker_i (.*);

  typedef logic [15:0] fld_t;

  function automatic logic [IN_W-1:0] pack_hit(fld_t ix, fld_t iy, fld_t iz,
      fld_t nx, fld_t ny, fld_t nz, fld_t n1, fld_t n2);
    return {n2, n1, nz, ny, nx, iz, iy, ix};
  endfunction

  // random component near a unit vector, sometimes anything at all
  function automatic fld_t rand_comp();
    if ($urandom_range(0, 9) == 0) return fld_t'($urandom);
    return fld_t'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic fld_t rand_index();
    case ($urandom_range(0, 5))
      0: return fld_t'($urandom);
      1: return fld_t'($urandom_range(0, 3));
      default: return fld_t'($urandom_range(16384, 40000));
    endcase
  endfunction

  // one hit per accepted beat; sender gaps between bursts
  task automatic send_hit(logic [IN_W-1:0] hit);
    s_tvalid <= 1'b1;
    s_tdata <= hit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hits_sent++;
  endtask

  task automatic send_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // receiver stall pattern: long ready windows, random short stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (stall_on) m_tready <= ($urandom_range(0, 3) != 0) || ($time % 2400 < 600);
    else m_tready <= 1'b1;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int burst, wait_cycles;
    fld_t c, a, b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: normal incidence, grazing, TIR, zero indices, extremes
    send_hit(pack_hit(16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000, 16'h6000));
    send_hit(pack_hit(16'h4000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000, 16'h6000));
    send_hit(pack_hit(16'h0, 16'hC000, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000, 16'h6000));
    send_hit(pack_hit(16'hD2BF, 16'hD2BF, 16'h0, 16'h0, 16'h4000, 16'h0,
                      16'h6000, 16'h4000));
    send_hit(pack_hit(16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000, 16'h0));
    send_hit(pack_hit(16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000));
    send_hit(pack_hit(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'hFFFF, 16'hFFFF));
    send_hit(pack_hit(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                      16'hFFFF, 16'h1));
    send_hit(pack_hit(16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000, 16'h4000));
    send_hit(pack_hit(16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h1, 16'hFFFF));
    send_hit(pack_hit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF));
    send_hit(pack_hit(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_hit(pack_hit(16'hE000, 16'hC893, 16'h0, 16'h0, 16'h4000, 16'h0,
                      16'h4000, 16'h6000));
    send_gap();
    stall_on <= 1'b1;
    // random bursts of hits with mostly unit-like vectors
    while (hits_sent < RANDOM_HITS + 13) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        a = rand_comp();
        b = rand_comp();
        c = rand_comp();
        send_hit(pack_hit(a, b, c, rand_comp(), rand_comp(), rand_comp(),
                          rand_index(), rand_index()));
      end
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d hits, %0d results checked, %0d with total internal reflection",
             hits_sent, checked, tir_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
